// ===== hdl/sgrm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrm_pkg
// Shared widths, constants and controller/datapath command types for the
// stereo gain ramp mixer.
// ----------------------------------------------------------------------------
package sgrm_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int GAIN_W          = 18;
    localparam int FRAMES_W        = 13;
    localparam int GAIN_FRAC_BITS  = 16;
    localparam int RAMP_EXTRA_BITS = 16;
    localparam int ACC_FRAC_BITS   = GAIN_FRAC_BITS + RAMP_EXTRA_BITS;
    localparam int ACC_W           = GAIN_W + RAMP_EXTRA_BITS;
    localparam int STEP_W          = ACC_W + 1;
    localparam int PROD_W          = SAMPLE_W + STEP_W;
    localparam int RND_W           = PROD_W - ACC_FRAC_BITS;
    localparam int MAX_FRAMES      = 4096;
    localparam int DIV_W           = ACC_W;
    localparam int DIV_CNT_W       = $clog2(DIV_W);

    localparam logic [GAIN_W-1:0]   GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = FRAMES_W'(MAX_FRAMES);

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_r;
        logic step_wr_l;
        logic step_wr_r;
        logic acc_en;
        logic mul_en;
        logic rnd_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                clip;
    } t_sat;

endpackage

// ===== hdl/sgrm_div.sv =====
// ----------------------------------------------------------------------------
// sgrm_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sgrm_div import sgrm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [FRAMES_W-1:0] i_divisor,
    output logic                o_done,
    output logic [DIV_W-1:0]    o_quotient
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FRAMES_W-1:0] r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [FRAMES_W-1:0] r_dvs;

    logic [FRAMES_W:0]   trial;
    logic [FRAMES_W:0]   trial_sub;
    logic                trial_ge;

    assign trial     = {r_rem, r_quo[DIV_W-1]};
    assign trial_ge  = trial >= {1'b0, r_dvs};
    assign trial_sub = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= trial_ge ? trial_sub[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], trial_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == '0)
        else $error("divider did not start a fresh pass");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == CNT_LAST |=> r_done && !r_busy)
        else $error("divider did not finish after the last step");

endmodule

// ===== hdl/sgrm_datapath.sv =====
// ----------------------------------------------------------------------------
// sgrm_datapath
// Gain state, ramp accumulators, step division, multiply, round/saturate,
// clip and peak tracking, and the output register.
// ----------------------------------------------------------------------------
module sgrm_datapath import sgrm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic [GAIN_W-1:0]          i_target_left_gain,
    input  logic [GAIN_W-1:0]          i_target_right_gain,
    input  logic [FRAMES_W-1:0]        i_buffer_frames,
    input  logic                       i_first_frame,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                       o_last_frame,
    output logic                       o_clipped,
    output logic [SAMPLE_W-1:0]        o_peak_left,
    output logic [SAMPLE_W-1:0]        o_peak_right
);

    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (ACC_FRAC_BITS - 1);

    function automatic t_sat round_sat(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        logic [RND_W-1:0]  v;
        t_sat              r;
        // half away from zero: negative products round with half minus one
        s = p + RND_HALF - {{(PROD_W-1){1'b0}}, p[PROD_W-1]};
        v = s[PROD_W-1:ACC_FRAC_BITS];
        r.clip = 1'b0;
        r.val  = v[SAMPLE_W-1:0];
        if (!v[RND_W-1] && (|v[RND_W-2:SAMPLE_W-1])) begin
            r.clip = 1'b1;
            r.val  = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (v[RND_W-1] && !(&v[RND_W-2:SAMPLE_W-1])) begin
            r.clip = 1'b1;
            r.val  = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] abs16(input logic [SAMPLE_W-1:0] x);
        return x[SAMPLE_W-1] ? (~x + 1'b1) : x;
    endfunction

    // state
    logic                r_peak_en;
    logic [GAIN_W-1:0]   r_cur_l, r_cur_r;
    logic [GAIN_W-1:0]   r_tgt_l, r_tgt_r;
    logic [ACC_W-1:0]    r_acc_l, r_acc_r;
    logic [STEP_W-1:0]   r_step_l, r_step_r;
    logic [FRAMES_W-1:0] r_frames;
    logic [FRAMES_W-1:0] r_len;
    logic                r_clip_sticky;
    logic [SAMPLE_W-1:0] r_peak_l, r_peak_r;
    logic                r_out_valid;

    // per-frame pipeline payload
    logic signed [SAMPLE_W-1:0] r_smp_l, r_smp_r;
    logic                       r_ramp;
    logic [ACC_W-1:0]           r_gain_l, r_gain_r;
    logic signed [PROD_W-1:0]   r_prod_l, r_prod_r;
    logic [SAMPLE_W-1:0]        r_rnd_l, r_rnd_r;
    logic                       r_clip_now;
    logic [SAMPLE_W-1:0]        r_out_l, r_out_r;
    logic                       r_out_last, r_out_clip;
    logic [SAMPLE_W-1:0]        r_out_pk_l, r_out_pk_r;

    logic [FRAMES_W-1:0] len_clamped;
    logic [GAIN_W:0]     diff_l, diff_r;
    logic [GAIN_W-1:0]   mag_l, mag_r;
    logic [DIV_W-1:0]    div_dividend;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [STEP_W-1:0]   quo_ext;
    logic [STEP_W-1:0]   acc_sum_l, acc_sum_r;
    t_sat                sat_l, sat_r;
    logic [SAMPLE_W-1:0] abs_l, abs_r;
    logic                n_clip;
    logic [SAMPLE_W-1:0] n_peak_l, n_peak_r;
    logic                frame_is_last;

    always_comb begin
        if (i_buffer_frames == '0) begin
            len_clamped = FRAMES_W'(1);
        end else if (i_buffer_frames > FRAMES_MAX) begin
            len_clamped = FRAMES_MAX;
        end else begin
            len_clamped = i_buffer_frames;
        end
    end

    assign diff_l = {1'b0, r_tgt_l} - {1'b0, r_cur_l};
    assign diff_r = {1'b0, r_tgt_r} - {1'b0, r_cur_r};
    assign mag_l  = diff_l[GAIN_W] ? GAIN_W'(-diff_l) : diff_l[GAIN_W-1:0];
    assign mag_r  = diff_r[GAIN_W] ? GAIN_W'(-diff_r) : diff_r[GAIN_W-1:0];
    assign div_dividend = {(i_cmd.div_sel_r ? mag_r : mag_l), {RAMP_EXTRA_BITS{1'b0}}};
    assign quo_ext = {1'b0, div_quo};

    sgrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign acc_sum_l = {1'b0, r_acc_l} + r_step_l;
    assign acc_sum_r = {1'b0, r_acc_r} + r_step_r;

    assign sat_l = round_sat(r_prod_l);
    assign sat_r = round_sat(r_prod_r);

    assign abs_l = abs16(r_rnd_l);
    assign abs_r = abs16(r_rnd_r);

    always_comb begin
        n_clip   = r_clip_sticky | r_clip_now;
        n_peak_l = r_peak_l;
        n_peak_r = r_peak_r;
        if (r_peak_en && abs_l > r_peak_l) begin
            n_peak_l = abs_l;
        end
        if (r_peak_en && abs_r > r_peak_r) begin
            n_peak_r = abs_r;
        end
    end

    assign frame_is_last = r_frames == FRAMES_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_en     <= 1'b0;
            r_cur_l       <= GAIN_UNITY;
            r_cur_r       <= GAIN_UNITY;
            r_tgt_l       <= GAIN_UNITY;
            r_tgt_r       <= GAIN_UNITY;
            r_acc_l       <= '0;
            r_acc_r       <= '0;
            r_step_l      <= '0;
            r_step_r      <= '0;
            r_frames      <= '0;
            r_clip_sticky <= 1'b0;
            r_peak_l      <= '0;
            r_peak_r      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_peak_en <= i_cfg_data;
            end
            if (i_cmd.load && i_first_frame) begin
                r_tgt_l       <= i_target_left_gain;
                r_tgt_r       <= i_target_right_gain;
                r_acc_l       <= {r_cur_l, {RAMP_EXTRA_BITS{1'b0}}};
                r_acc_r       <= {r_cur_r, {RAMP_EXTRA_BITS{1'b0}}};
                r_frames      <= len_clamped;
                r_clip_sticky <= 1'b0;
                r_peak_l      <= '0;
                r_peak_r      <= '0;
            end
            if (i_cmd.step_wr_l) begin
                r_step_l <= diff_l[GAIN_W] ? -quo_ext : quo_ext;
            end
            if (i_cmd.step_wr_r) begin
                r_step_r <= diff_r[GAIN_W] ? -quo_ext : quo_ext;
            end
            if (i_cmd.acc_en && r_frames != '0) begin
                r_acc_l <= acc_sum_l[ACC_W-1:0];
                r_acc_r <= acc_sum_r[ACC_W-1:0];
            end
            if (i_cmd.out_load && r_ramp) begin
                r_clip_sticky <= n_clip;
                r_peak_l      <= n_peak_l;
                r_peak_r      <= n_peak_r;
                r_frames      <= r_frames - 1'b1;
                if (frame_is_last) begin
                    r_cur_l <= r_tgt_l;
                    r_cur_r <= r_tgt_r;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp_l <= i_left_sample;
            r_smp_r <= i_right_sample;
            if (i_first_frame) begin
                r_len <= len_clamped;
            end
        end
        if (i_cmd.acc_en) begin
            // outside a buffer the committed gain is used as is
            r_ramp <= r_frames != '0;
            if (r_frames != '0) begin
                r_gain_l <= acc_sum_l[ACC_W-1:0];
                r_gain_r <= acc_sum_r[ACC_W-1:0];
            end else begin
                r_gain_l <= {r_cur_l, {RAMP_EXTRA_BITS{1'b0}}};
                r_gain_r <= {r_cur_r, {RAMP_EXTRA_BITS{1'b0}}};
            end
        end
        if (i_cmd.mul_en) begin
            r_prod_l <= r_smp_l * $signed({1'b0, r_gain_l});
            r_prod_r <= r_smp_r * $signed({1'b0, r_gain_r});
        end
        if (i_cmd.rnd_en) begin
            r_rnd_l    <= sat_l.val;
            r_rnd_r    <= sat_r.val;
            r_clip_now <= sat_l.clip | sat_r.clip;
        end
        if (i_cmd.out_load) begin
            r_out_l <= r_rnd_l;
            r_out_r <= r_rnd_r;
            if (r_ramp) begin
                r_out_last <= frame_is_last;
                r_out_clip <= n_clip;
                r_out_pk_l <= r_peak_en ? n_peak_l : '0;
                r_out_pk_r <= r_peak_en ? n_peak_r : '0;
            end else begin
                r_out_last <= 1'b0;
                r_out_clip <= 1'b0;
                r_out_pk_l <= '0;
                r_out_pk_r <= '0;
            end
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_left_out   = r_out_l;
    assign o_right_out  = r_out_r;
    assign o_last_frame = r_out_last;
    assign o_clipped    = r_out_clip;
    assign o_peak_left  = r_out_pk_l;
    assign o_peak_right = r_out_pk_r;

    a_commit_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_ramp && frame_is_last && !i_cmd.load
            |=> r_cur_l == r_tgt_l && r_cur_r == r_tgt_r)
        else $error("gains not committed to target at buffer end");

    a_peak_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && !r_peak_en |=> o_peak_left == '0 && o_peak_right == '0)
        else $error("peaks reported while metering disabled");

endmodule

// ===== hdl/sgrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgrm_ctrl
// Frame sequencer: input handshake, step division on a buffer's first
// frame, then accumulate, multiply, round and output stages.
// ----------------------------------------------------------------------------
module sgrm_ctrl import sgrm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_first_frame,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DIVL_GO  = 8'b0000_0010,
        ST_DIVL_RUN = 8'b0000_0100,
        ST_DIVR_RUN = 8'b0000_1000,
        ST_ACC      = 8'b0001_0000,
        ST_MUL      = 8'b0010_0000,
        ST_RND      = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_first_frame ? ST_DIVL_GO : ST_ACC;
                end
            end
            ST_DIVL_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVL_RUN;
            end
            ST_DIVL_RUN: begin
                if (i_status.div_done) begin
                    // left quotient is taken as the right division starts
                    o_cmd.step_wr_l = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_r = 1'b1;
                    n_state         = ST_DIVR_RUN;
                end
            end
            ST_DIVR_RUN: begin
                if (i_status.div_done) begin
                    o_cmd.step_wr_r = 1'b1;
                    n_state         = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_RND;
            end
            ST_RND: begin
                o_cmd.rnd_en = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_out_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output register overwritten while its word is pending");

    a_div_then_accumulate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step_wr_r |=> o_cmd.acc_en && o_in_stall)
        else $error("accumulate stage did not follow the step division");

endmodule

// ===== hdl/stereo_gain_ramp_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_gain_ramp_mixer_unit
// A frame taken in idle runs the accumulate, multiply and round stages
// into the output register, which waits while the output is stalled;
// a buffer's first frame first runs two 34-step divisions on the shared
// radix-2 divider. No new frame is taken until the current one is loaded.
// Reset (synchronous, active low) sets unity gains, no open buffer and
// metering disabled; there is no clearing pass.
// ----------------------------------------------------------------------------
module stereo_gain_ramp_mixer_unit import sgrm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic [GAIN_W-1:0]          i_target_left_gain,
    input  logic [GAIN_W-1:0]          i_target_right_gain,
    input  logic [FRAMES_W-1:0]        i_buffer_frames,
    input  logic                       i_first_frame,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                       o_last_frame,
    output logic                       o_clipped,
    output logic [SAMPLE_W-1:0]        o_peak_left,
    output logic [SAMPLE_W-1:0]        o_peak_right,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // the enable register takes a word in any cycle
    assign o_cfg_ready = 1'b1;

    sgrm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_first_frame (i_first_frame),
        .o_in_stall    (o_in_stall),
        .o_cmd         (dp_cmd),
        .i_status      (dp_status)
    );

    sgrm_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .i_cfg_valid         (i_cfg_valid & o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_left_sample       (i_left_sample),
        .i_right_sample      (i_right_sample),
        .i_target_left_gain  (i_target_left_gain),
        .i_target_right_gain (i_target_right_gain),
        .i_buffer_frames     (i_buffer_frames),
        .i_first_frame       (i_first_frame),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_left_out          (o_left_out),
        .o_right_out         (o_right_out),
        .o_last_frame        (o_last_frame),
        .o_clipped           (o_clipped),
        .o_peak_left         (o_peak_left),
        .o_peak_right        (o_peak_right)
    );

endmodule
